@@ rtl/ilcd_pkg.sv @@
// Shared types, constants and the drug table for the infusion limit checker.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package ilcd_pkg;

    // Field widths
    localparam int RATE_W    = 16;
    localparam int VOL_W     = 16;
    localparam int CODE_W    = 16;
    localparam int WEIGHT_W  = 8;
    localparam int CONC_W    = 20;
    localparam int DOSE_W    = 32;
    localparam int PROD_W    = RATE_W + CONC_W;
    localparam int VERDICT_W = 3;

    // Stream payloads
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MIN_WEIGHT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MAX_WEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MAX_VOLUME = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HARD_MAX   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HARD_MIN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SOFT_MAX   = 3'd5;

    localparam logic [WEIGHT_W-1:0] RST_MIN_WEIGHT = 8'd1;
    localparam logic [WEIGHT_W-1:0] RST_MAX_WEIGHT = 8'd250;
    localparam logic [VOL_W-1:0]    RST_MAX_VOLUME = 16'd1000;
    localparam logic [RATE_W-1:0]   RST_HARD_MAX   = 16'd500;
    localparam logic [RATE_W-1:0]   RST_HARD_MIN   = 16'd1;
    localparam logic [RATE_W-1:0]   RST_SOFT_MAX   = 16'd300;

    // Drug table
    localparam int DRUG_TABLE_CAP   = 64;
    localparam int DRUG_IDX_W       = 6;
    localparam int DRUG_ENTRIES_DEF = 6;

    // Division by 60: drop two bits, then divide by 15 through a reciprocal.
    localparam int                   Y_W     = 30;
    localparam int                   RECIP_W = 31;
    localparam int                   P_W     = Y_W + RECIP_W;
    localparam int                   RECIP_SHIFT = 34;
    localparam logic [RECIP_W-1:0]   RECIP_15    = 31'h4444_4444; // floor(2^34 / 15)
    localparam int                   Q60_W   = P_W - RECIP_SHIFT;

    // Division by weight
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES = (Q60_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int DIV_WORK_W = DIV_STAGES * DIV_BITS_PER_STAGE;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_PASS         = 3'd0,
        VERDICT_SOFT_WARN    = 3'd1,
        VERDICT_OVER_MAX     = 3'd2,
        VERDICT_UNDER_MIN    = 3'd3,
        VERDICT_VOLUME       = 3'd4,
        VERDICT_WEIGHT       = 3'd5,
        VERDICT_UNKNOWN_DRUG = 3'd6
    } verdict_t;

    typedef enum logic [1:0] {
        DOSE_ZERO = 2'd0,
        DOSE_SAT  = 2'd1,
        DOSE_DIV  = 2'd2
    } dose_kind_t;

    typedef struct packed {
        logic               valid;
        logic [CODE_W-1:0]  code;
        logic [CONC_W-1:0]  conc;
        logic [RATE_W-1:0]  rate_hi;
        logic [RATE_W-1:0]  rate_lo;
    } drug_row_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] min_weight;
        logic [WEIGHT_W-1:0] max_weight;
        logic [VOL_W-1:0]    max_volume;
        logic [RATE_W-1:0]   rate_ceil;
        logic [RATE_W-1:0]   rate_floor;
        logic [RATE_W-1:0]   soft_max;
    } cfg_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [CODE_W-1:0]   code;
        logic [VOL_W-1:0]    volume;
        logic [RATE_W-1:0]   rate;
    } req_t;

    typedef struct packed {
        verdict_t            verdict;
        dose_kind_t          kind;
        logic [RATE_W-1:0]   rate;
        logic [CONC_W-1:0]   conc;
        logic [WEIGHT_W-1:0] weight;
    } chk_beat_t;

    typedef struct packed {
        verdict_t            verdict;
        dose_kind_t          kind;
        logic [Q60_W-1:0]    quot;
        logic [WEIGHT_W-1:0] weight;
    } q60_beat_t;

    typedef struct packed {
        verdict_t         verdict;
        dose_kind_t       kind;
        logic [Q60_W-1:0] quot;
    } res_beat_t;

    function automatic drug_row_t drug_row(input logic [DRUG_IDX_W-1:0] idx);
        drug_row_t row;
        row = '0;
        unique case (idx)
            6'd0:    row = '{1'b1, 16'd1, 20'd1000,    16'd50,   16'd1};
            6'd1:    row = '{1'b1, 16'd2, 20'd50,      16'd200,  16'd10};
            6'd2:    row = '{1'b1, 16'd3, 20'd1000,    16'd10,   16'd1};
            6'd3:    row = '{1'b1, 16'd4, 20'd1000000, 16'd1000, 16'd100};
            6'd4:    row = '{1'b1, 16'd5, 20'd400000,  16'd20,   16'd2};
            6'd5:    row = '{1'b1, 16'd6, 20'd1000,    16'd20,   16'd1};
            default: row = '0;
        endcase
        return row;
    endfunction

endpackage

@@ rtl/ilcd_check.sv @@
// First pipeline stage: drug lookup, limit checks and verdict.
// Depends on ilcd_pkg for the drug table, register and beat types.
module ilcd_check #(
    parameter int DRUG_ENTRIES = ilcd_pkg::DRUG_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ilcd_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  ilcd_pkg::req_t      in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output ilcd_pkg::chk_beat_t out_beat
);

    logic                valid_reg;
    ilcd_pkg::chk_beat_t beat_reg;
    ilcd_pkg::chk_beat_t beat_next;
    logic                hit;
    ilcd_pkg::drug_row_t row;
    logic [ilcd_pkg::RATE_W-1:0] eff_ceil;
    logic [ilcd_pkg::RATE_W-1:0] eff_floor;

    // Lookup: scan from the top so the lowest matching entry wins
    always_comb begin
        ilcd_pkg::drug_row_t entry;
        hit = 1'b0;
        row = '0;
        for (int i = ilcd_pkg::DRUG_TABLE_CAP - 1; i >= 0; i--) begin
            entry = ilcd_pkg::drug_row(ilcd_pkg::DRUG_IDX_W'(i));
            if (i < DRUG_ENTRIES && entry.valid && entry.code == in_beat.code) begin
                hit = 1'b1;
                row = entry;
            end
        end
    end

    assign eff_ceil  = (row.rate_hi < cfg.rate_ceil) ? row.rate_hi : cfg.rate_ceil;
    assign eff_floor = (row.rate_lo > cfg.rate_floor) ? row.rate_lo : cfg.rate_floor;

    always_comb begin
        beat_next.rate   = in_beat.rate;
        beat_next.conc   = row.conc;
        beat_next.weight = in_beat.weight;

        if (!hit || in_beat.weight == '0 || in_beat.weight < cfg.min_weight) begin
            beat_next.kind = ilcd_pkg::DOSE_ZERO;
        end else begin
            beat_next.kind = ilcd_pkg::DOSE_DIV;
        end

        priority if (!hit) begin
            beat_next.verdict = ilcd_pkg::VERDICT_UNKNOWN_DRUG;
        end else if (in_beat.weight < cfg.min_weight || in_beat.weight > cfg.max_weight) begin
            beat_next.verdict = ilcd_pkg::VERDICT_WEIGHT;
        end else if (in_beat.volume == '0 || in_beat.volume > cfg.max_volume) begin
            beat_next.verdict = ilcd_pkg::VERDICT_VOLUME;
        end else if (in_beat.rate > eff_ceil) begin
            beat_next.verdict = ilcd_pkg::VERDICT_OVER_MAX;
        end else if (in_beat.rate < eff_floor) begin
            beat_next.verdict = ilcd_pkg::VERDICT_UNDER_MIN;
        end else if (in_beat.rate > cfg.soft_max) begin
            beat_next.verdict = ilcd_pkg::VERDICT_SOFT_WARN;
        end else begin
            beat_next.verdict = ilcd_pkg::VERDICT_PASS;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

@@ rtl/ilcd_div60.sv @@
// Product stage and division by 60 (shift by two, reciprocal multiply by 1/15,
// one-step correction). Three register stages. Depends on ilcd_pkg.
module ilcd_div60 (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ilcd_pkg::chk_beat_t in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output ilcd_pkg::q60_beat_t out_beat
);

    // Stage B: product
    logic                        valid_b_reg;
    logic [ilcd_pkg::PROD_W-1:0] prod;
    logic [ilcd_pkg::Y_W-1:0]    y_b_reg;
    ilcd_pkg::verdict_t          verdict_b_reg;
    ilcd_pkg::dose_kind_t        kind_b_reg;
    ilcd_pkg::dose_kind_t        kind_b_next;
    logic [ilcd_pkg::WEIGHT_W-1:0] weight_b_reg;

    // Stage C: reciprocal product
    logic                        valid_c_reg;
    logic [ilcd_pkg::P_W-1:0]    p_c_reg;
    logic [ilcd_pkg::Y_W-1:0]    y_c_reg;
    ilcd_pkg::verdict_t          verdict_c_reg;
    ilcd_pkg::dose_kind_t        kind_c_reg;
    logic [ilcd_pkg::WEIGHT_W-1:0] weight_c_reg;

    // Stage D: corrected quotient
    logic                        valid_d_reg;
    ilcd_pkg::q60_beat_t         beat_d_reg;
    ilcd_pkg::q60_beat_t         beat_d_next;
    logic [ilcd_pkg::Q60_W-1:0]  q_est;
    logic [ilcd_pkg::RECIP_W-1:0] resid;

    logic ready_b;
    logic ready_c;
    logic ready_d;

    assign ready_d  = !valid_d_reg || out_ready;
    assign ready_c  = !valid_c_reg || ready_d;
    assign ready_b  = !valid_b_reg || ready_c;
    assign in_ready = ready_b;

    assign prod = ilcd_pkg::PROD_W'(in_beat.rate) * ilcd_pkg::PROD_W'(in_beat.conc);

    always_comb begin
        kind_b_next = in_beat.kind;
        if (in_beat.kind == ilcd_pkg::DOSE_DIV &&
            prod[ilcd_pkg::PROD_W-1:ilcd_pkg::DOSE_W] != '0) begin
            kind_b_next = ilcd_pkg::DOSE_SAT;
        end
    end

    // Estimate is at most one below floor(y / 15)
    assign q_est = p_c_reg[ilcd_pkg::P_W-1:ilcd_pkg::RECIP_SHIFT];
    assign resid = ilcd_pkg::RECIP_W'(y_c_reg)
                 - ({q_est, 4'b0000} - ilcd_pkg::RECIP_W'(q_est));

    always_comb begin
        beat_d_next.verdict = verdict_c_reg;
        beat_d_next.kind    = kind_c_reg;
        beat_d_next.weight  = weight_c_reg;
        beat_d_next.quot    = q_est;
        if (resid >= ilcd_pkg::RECIP_W'(15)) begin
            beat_d_next.quot = q_est + ilcd_pkg::Q60_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
        end else begin
            if (ready_b) begin
                valid_b_reg <= in_valid;
            end
            if (ready_c) begin
                valid_c_reg <= valid_b_reg;
            end
            if (ready_d) begin
                valid_d_reg <= valid_c_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_b && in_valid) begin
            y_b_reg       <= prod[ilcd_pkg::DOSE_W-1:2];
            verdict_b_reg <= in_beat.verdict;
            kind_b_reg    <= kind_b_next;
            weight_b_reg  <= in_beat.weight;
        end
        if (ready_c && valid_b_reg) begin
            p_c_reg       <= ilcd_pkg::P_W'(y_b_reg) * ilcd_pkg::P_W'(ilcd_pkg::RECIP_15);
            y_c_reg       <= y_b_reg;
            verdict_c_reg <= verdict_b_reg;
            kind_c_reg    <= kind_b_reg;
            weight_c_reg  <= weight_b_reg;
        end
        if (ready_d && valid_c_reg) begin
            beat_d_reg <= beat_d_next;
        end
    end

    assign out_valid = valid_d_reg;
    assign out_beat  = beat_d_reg;

    a_recip_error_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_c_reg |-> resid < ilcd_pkg::RECIP_W'(30))
        else $error("reciprocal estimate off by more than one");

endmodule

@@ rtl/ilcd_wdiv.sv @@
// Pipelined restoring divider: quotient of the divide-by-60 result by weight,
// a few quotient bits per register stage. Depends on ilcd_pkg.
module ilcd_wdiv (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ilcd_pkg::q60_beat_t in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output ilcd_pkg::res_beat_t out_beat
);

    localparam int STAGES = ilcd_pkg::DIV_STAGES;
    localparam int WORK_W = ilcd_pkg::DIV_WORK_W;
    localparam int WT_W   = ilcd_pkg::WEIGHT_W;

    typedef struct packed {
        ilcd_pkg::verdict_t   verdict;
        ilcd_pkg::dose_kind_t kind;
        logic [WT_W-1:0]      divisor;
        logic [WT_W-1:0]      rem;
        logic [WORK_W-1:0]    work;
    } wdiv_stage_t;

    wdiv_stage_t         stage_src  [0:STAGES-1];
    wdiv_stage_t         stage_reg  [1:STAGES];
    wdiv_stage_t         stage_next [1:STAGES];
    logic [STAGES-1:0]   src_valid;
    logic [STAGES:1]     valid_reg;
    logic [STAGES+1:1]   stage_ready;

    assign stage_src[0].verdict = in_beat.verdict;
    assign stage_src[0].kind    = in_beat.kind;
    assign stage_src[0].divisor = in_beat.weight;
    assign stage_src[0].rem     = '0;
    assign stage_src[0].work    = WORK_W'(in_beat.quot);
    assign src_valid[0]         = in_valid;

    assign stage_ready[STAGES+1] = out_ready;
    assign in_ready              = stage_ready[1];

    for (genvar s = 1; s <= STAGES; s++) begin : g_stage
        if (s < STAGES) begin : g_link
            assign stage_src[s] = stage_reg[s];
            assign src_valid[s] = valid_reg[s];
        end

        assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];

        always_comb begin
            wdiv_stage_t      acc;
            logic [WT_W:0]    trial;
            acc = stage_src[s-1];
            for (int k = 0; k < ilcd_pkg::DIV_BITS_PER_STAGE; k++) begin
                trial = {acc.rem, acc.work[WORK_W-1]};
                if (trial >= {1'b0, acc.divisor}) begin
                    trial    = trial - {1'b0, acc.divisor};
                    acc.work = {acc.work[WORK_W-2:0], 1'b1};
                end else begin
                    acc.work = {acc.work[WORK_W-2:0], 1'b0};
                end
                acc.rem = trial[WT_W-1:0];
            end
            stage_next[s] = acc;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (stage_ready[s]) begin
                valid_reg[s] <= src_valid[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[s] && src_valid[s-1]) begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign out_valid        = valid_reg[STAGES];
    assign out_beat.verdict = stage_reg[STAGES].verdict;
    assign out_beat.kind    = stage_reg[STAGES].kind;
    assign out_beat.quot    = stage_reg[STAGES].work[ilcd_pkg::Q60_W-1:0];

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[STAGES] && stage_reg[STAGES].divisor != '0)
            |-> stage_reg[STAGES].rem < stage_reg[STAGES].divisor)
        else $error("divider remainder not below divisor");

endmodule

@@ rtl/infusion_limit_check_and_dose.sv @@
// Top level of the infusion limit checker: configuration registers, the check,
// divide-by-60 and weight-divider pipelines, and the output register.
// Depends on ilcd_pkg, ilcd_check, ilcd_div60 and ilcd_wdiv.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata: rate, volume, drug_code, weight
//  m_       | out | m_tvalid/m_tready  | m_tdata: verdict, dose_mcg_per_kg_min
//  cfg_     | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// One beat enters per cycle unless m_tready stalls. Register stages: check 1,
// product and divide by 60 3, weight divider 7 at four quotient bits a stage,
// output register 1. Each stage has its own valid bit and takes a new beat whenever
// it is empty or its successor moves, so bubbles close up under a stalled m_tready.
// Synchronous active-low reset clears the valid bits and loads register defaults.
module infusion_limit_check_and_dose #(
    parameter int DRUG_ENTRIES = ilcd_pkg::DRUG_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] rate_ml_per_hour, [31:16] volume_ml, [47:32] drug_code, [55:48] weight_kg
    input  logic [ilcd_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] verdict, [34:3] dose_mcg_per_kg_min, [39:35] zero
    output logic [ilcd_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [ilcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ilcd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    ilcd_pkg::cfg_t       cfg_reg;
    ilcd_pkg::cfg_t       cfg_next;
    ilcd_pkg::req_t       req;

    logic                 chk_valid;
    logic                 chk_ready;
    ilcd_pkg::chk_beat_t  chk_beat;
    logic                 q60_valid;
    logic                 q60_ready;
    ilcd_pkg::q60_beat_t  q60_beat;
    logic                 res_valid;
    logic                 res_ready;
    ilcd_pkg::res_beat_t  res_beat;

    logic                              m_valid_reg;
    logic [ilcd_pkg::M_TDATA_W-1:0]    m_data_reg;
    logic [ilcd_pkg::M_TDATA_W-1:0]    m_data_next;
    logic [ilcd_pkg::DOSE_W-1:0]       dose;

    // Configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                ilcd_pkg::CFG_IDX_MIN_WEIGHT: cfg_next.min_weight = cfg_wdata[7:0];
                ilcd_pkg::CFG_IDX_MAX_WEIGHT: cfg_next.max_weight = cfg_wdata[7:0];
                ilcd_pkg::CFG_IDX_MAX_VOLUME: cfg_next.max_volume = cfg_wdata;
                ilcd_pkg::CFG_IDX_HARD_MAX:   cfg_next.rate_ceil  = cfg_wdata;
                ilcd_pkg::CFG_IDX_HARD_MIN:   cfg_next.rate_floor = cfg_wdata;
                ilcd_pkg::CFG_IDX_SOFT_MAX:   cfg_next.soft_max   = cfg_wdata;
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_weight <= ilcd_pkg::RST_MIN_WEIGHT;
            cfg_reg.max_weight <= ilcd_pkg::RST_MAX_WEIGHT;
            cfg_reg.max_volume <= ilcd_pkg::RST_MAX_VOLUME;
            cfg_reg.rate_ceil  <= ilcd_pkg::RST_HARD_MAX;
            cfg_reg.rate_floor <= ilcd_pkg::RST_HARD_MIN;
            cfg_reg.soft_max   <= ilcd_pkg::RST_SOFT_MAX;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign req.rate   = s_tdata[15:0];
    assign req.volume = s_tdata[31:16];
    assign req.code   = s_tdata[47:32];
    assign req.weight = s_tdata[55:48];

    ilcd_check #(
        .DRUG_ENTRIES (DRUG_ENTRIES)
    ) u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_beat   (req),
        .out_valid (chk_valid),
        .out_ready (chk_ready),
        .out_beat  (chk_beat)
    );

    ilcd_div60 u_div60 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chk_valid),
        .in_ready  (chk_ready),
        .in_beat   (chk_beat),
        .out_valid (q60_valid),
        .out_ready (q60_ready),
        .out_beat  (q60_beat)
    );

    ilcd_wdiv u_wdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q60_valid),
        .in_ready  (q60_ready),
        .in_beat   (q60_beat),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_beat  (res_beat)
    );

    always_comb begin
        unique case (res_beat.kind)
            ilcd_pkg::DOSE_ZERO: dose = '0;
            ilcd_pkg::DOSE_SAT:  dose = '1;
            ilcd_pkg::DOSE_DIV:  dose = ilcd_pkg::DOSE_W'(res_beat.quot);
            default:             dose = '0;
        endcase
        m_data_next = {5'b00000, dose, res_beat.verdict};
    end

    // Output register: hold while the sink stalls
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_unknown_drug_zero_dose: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] == ilcd_pkg::VERDICT_UNKNOWN_DRUG)
            |-> m_tdata[34:3] == '0)
        else $error("unknown drug with nonzero dose");

    a_empty_output_takes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    a_reset_clears_output: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("output valid straight after reset");

endmodule
